### rtl/core/nmlet_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package nmlet_pkg;
    localparam int VALUE_BITS  = 48;
    localparam int GAIN_BITS   = 47;
    localparam int CNT_BITS    = 32;
    localparam int SUM_BITS    = 64;
    localparam int LENGTH_BITS = 32;

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_TRANS = 2'd1,
        MODE_MEAS  = 2'd2,
        MODE_CLEAR = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        REG_GAIN   = 2'd0,
        REG_OFFSET = 2'd1,
        REG_FIXPT  = 2'd2,
        REG_BAND   = 2'd3
    } t_reg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_LO,
        ST_SQ_MID,
        ST_SQ_HI,
        ST_DIV,
        ST_SUM,
        ST_DIST,
        ST_STAT,
        ST_SQR,
        ST_ACC,
        ST_OUT
    } t_state;
endpackage
`default_nettype wire

### rtl/core/nmlet_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface nmlet_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic signed [47:0] start_value;
    modport source (output valid, mode, start_value, input ready);
    modport sink (input valid, mode, start_value, output ready);
endinterface

interface nmlet_out_if;
    logic        valid;
    logic        ready;
    logic signed [47:0] next_value;
    logic        laminar_now;
    logic        episode_ended;
    logic [31:0] episode_length;
    logic [31:0] episode_total;
    logic [63:0] length_sum;
    logic [63:0] length_square_sum;
    logic [31:0] length_peak;
    modport source (output valid, next_value, laminar_now, episode_ended, episode_length,
        episode_total, length_sum, length_square_sum, length_peak, input ready);
    modport sink (input valid, next_value, laminar_now, episode_ended, episode_length,
        episode_total, length_sum, length_square_sum, length_peak, output ready);
endinterface
`default_nettype wire

### rtl/core/nmlet_div.sv
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider, one quotient bit per cycle; quotient kept mod 2^48.
module nmlet_div #(
    parameter int FRACTION_BITS = 44
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_start,
    input  wire [46:0]  i_num,
    input  wire [64:0]  i_den,
    output logic        o_done,
    output logic [47:0] o_quo
);
    localparam int NB = nmlet_pkg::GAIN_BITS + FRACTION_BITS;
    localparam int CW = $clog2(NB + 1);

    logic [NB-1:0] r_num;
    logic [65:0]   r_rem;
    logic [64:0]   r_den;
    logic [47:0]   r_quo;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic [65:0]   w_sh;
    logic [66:0]   w_diff;

    assign w_sh   = {r_rem[64:0], r_num[NB-1]};
    assign w_diff = {1'b0, w_sh} - {2'b00, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NB);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
        if (i_start) begin
            r_num <= {i_num, FRACTION_BITS'(0)};
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= r_num << 1;
            if (!w_diff[66]) begin
                r_rem <= w_diff[65:0];
                r_quo <= {r_quo[46:0], 1'b1};
            end else begin
                r_rem <= w_sh;
                r_quo <= {r_quo[46:0], 1'b0};
            end
        end
    end
    assign o_quo = r_quo;
endmodule
`default_nettype wire

### rtl/core/neuron_map_laminar_episode_tracker.sv
`timescale 1ns / 1ps
`default_nettype none
// channel | dir | beat
// s_in    | in  | mode, start_value
// m_out   | out | next_value, laminar flags, episode length, statistics
// apb     | in  | map_gain, map_offset, fixed_point_value, band_half_width at 8*i
// Load and clear put out their result in the cycle after the accept.
// Steps pass through the squaring states, the radix-2 restoring divider and the sum,
// distance, statistics, square and accumulate states before their result beat.
// One shared 32x32 multiplier forms the square and the length square.
// Reset is synchronous; not ready from accept until the result beat is taken, and the
// next input beat can be taken in the cycle after that.
module neuron_map_laminar_episode_tracker #(
    parameter int FRACTION_BITS = 44
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    nmlet_in_if.sink   s_in,
    nmlet_out_if.source m_out,
    input  wire        psel,
    input  wire        penable,
    input  wire        pwrite,
    input  wire [4:0]  paddr,
    input  wire [63:0] pwdata,
    output logic [63:0] prdata,
    output logic       pready
);
    localparam logic [nmlet_pkg::LENGTH_BITS-1:0] RUN_MAX = '1;

    nmlet_pkg::t_state r_st, n_st;
    logic [46:0] r_gain, r_band;
    logic signed [47:0] r_off, r_fp;
    logic signed [47:0] r_x, r_nx;
    logic r_lam;
    logic [nmlet_pkg::LENGTH_BITS-1:0] r_run;
    logic [31:0] r_tot, r_peak, r_len;
    logic [63:0] r_sum, r_sq;
    logic r_end;
    logic [1:0] r_mode;
    logic [47:0] r_mag;
    logic [95:0] r_prod;
    logic [64:0] r_den;
    logic r_wasout, r_lensat;
    logic r_divgo;
    logic [31:0] w_ma, w_mb;
    logic [63:0] w_mp;
    logic div_start, div_done;
    logic [47:0] div_quo;
    logic signed [49:0] w_s;
    logic signed [48:0] w_d;
    logic [48:0] w_ad;
    logic signed [48:0] w_dp;
    logic [48:0] w_adp;
    logic [nmlet_pkg::LENGTH_BITS-1:0] w_run1;
    logic [64:0] w_sum;

    assign pready = 1'b1;
    always_comb begin
        prdata = '0;
        unique case (nmlet_pkg::t_reg'(paddr[4:3]))
            nmlet_pkg::REG_GAIN:   prdata = {17'd0, r_gain};
            nmlet_pkg::REG_OFFSET: prdata = {{16{r_off[47]}}, r_off};
            nmlet_pkg::REG_FIXPT:  prdata = {{16{r_fp[47]}}, r_fp};
            nmlet_pkg::REG_BAND:   prdata = {17'd0, r_band};
            default: prdata = '0;
        endcase
    end

    // shared multiplier
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_st)
            nmlet_pkg::ST_SQ_LO:  begin w_ma = r_mag[31:0]; w_mb = r_mag[31:0]; end
            nmlet_pkg::ST_SQ_MID: begin w_ma = r_mag[31:0]; w_mb = {16'd0, r_mag[47:32]}; end
            nmlet_pkg::ST_SQ_HI:  begin w_ma = {16'd0, r_mag[47:32]}; w_mb = {16'd0, r_mag[47:32]}; end
            nmlet_pkg::ST_SQR:    begin w_ma = r_len; w_mb = r_len; end
            default: ;
        endcase
    end
    assign w_mp = w_ma * w_mb;

    nmlet_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(r_gain), .i_den(r_den), .o_done(div_done), .o_quo(div_quo));

    assign w_s  = $signed({3'b000, div_quo[46:0]}) + 50'(r_off);
    assign w_d  = 49'(r_nx) - 49'(r_fp);
    assign w_ad = w_d[48] ? 49'(-w_d) : 49'(w_d);
    assign w_dp  = 49'(r_x) - 49'(r_fp);
    assign w_adp = w_dp[48] ? 49'(-w_dp) : 49'(w_dp);
    assign w_run1 = (r_run == RUN_MAX) ? r_run : r_run + 1'b1;

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            nmlet_pkg::ST_IDLE: if (s_in.valid) begin
                n_st = (s_in.mode == nmlet_pkg::MODE_TRANS || s_in.mode == nmlet_pkg::MODE_MEAS)
                    ? nmlet_pkg::ST_SQ_LO : nmlet_pkg::ST_OUT;
            end
            nmlet_pkg::ST_SQ_LO:  n_st = nmlet_pkg::ST_SQ_MID;
            nmlet_pkg::ST_SQ_MID: n_st = nmlet_pkg::ST_SQ_HI;
            nmlet_pkg::ST_SQ_HI:  begin n_st = nmlet_pkg::ST_DIV; end
            nmlet_pkg::ST_DIV: begin
                if (div_done) n_st = nmlet_pkg::ST_SUM;
            end
            nmlet_pkg::ST_SUM:  n_st = nmlet_pkg::ST_DIST;
            nmlet_pkg::ST_DIST: n_st = nmlet_pkg::ST_STAT;
            nmlet_pkg::ST_STAT: n_st = nmlet_pkg::ST_SQR;
            nmlet_pkg::ST_SQR:  n_st = nmlet_pkg::ST_ACC;
            nmlet_pkg::ST_ACC:  n_st = nmlet_pkg::ST_OUT;
            nmlet_pkg::ST_OUT:  if (m_out.ready) n_st = nmlet_pkg::ST_IDLE;
            default: n_st = nmlet_pkg::ST_IDLE;
        endcase
    end

    assign div_start = r_divgo;
    assign s_in.ready = (r_st == nmlet_pkg::ST_IDLE);
    assign m_out.valid = (r_st == nmlet_pkg::ST_OUT);
    assign m_out.next_value = r_x;
    assign m_out.laminar_now = r_lam;
    assign m_out.episode_ended = r_end;
    assign m_out.episode_length = r_len;
    assign m_out.episode_total = r_tot;
    assign m_out.length_sum = r_sum;
    assign m_out.length_square_sum = r_sq;
    assign m_out.length_peak = r_peak;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= nmlet_pkg::ST_IDLE;
            r_gain <= 47'd84442493013197;
            r_off <= -48'sd51569539174795;
            r_fp <= -48'sd31058273865894;
            r_band <= 47'd1759218604442;
            r_x <= '0; r_lam <= 1'b0; r_run <= '0;
            r_tot <= '0; r_sum <= '0; r_sq <= '0; r_peak <= '0;
            r_divgo <= 1'b0;
        end else begin
            r_st <= n_st;
            r_divgo <= (r_st == nmlet_pkg::ST_SQ_HI);
            if (psel && penable && pwrite) begin
                unique case (nmlet_pkg::t_reg'(paddr[4:3]))
                    nmlet_pkg::REG_GAIN:   r_gain <= pwdata[46:0];
                    nmlet_pkg::REG_OFFSET: r_off <= pwdata[47:0];
                    nmlet_pkg::REG_FIXPT:  r_fp <= pwdata[47:0];
                    nmlet_pkg::REG_BAND:   r_band <= pwdata[46:0];
                    default: ;
                endcase
            end
            case (r_st)
                nmlet_pkg::ST_IDLE: if (s_in.valid) begin
                    r_mode <= s_in.mode;
                    r_end <= 1'b0;
                    r_len <= '0;
                    r_mag <= r_x[47] ? 48'(-r_x) : r_x;
                    r_prod <= '0;
                    if (s_in.mode == nmlet_pkg::MODE_LOAD) begin
                        r_x <= s_in.start_value; r_lam <= 1'b0; r_run <= '0;
                    end else if (s_in.mode == nmlet_pkg::MODE_CLEAR) begin
                        r_tot <= '0; r_sum <= '0; r_sq <= '0; r_peak <= '0;
                    end
                end
                nmlet_pkg::ST_SQ_LO:  r_prod <= {32'd0, w_mp};
                nmlet_pkg::ST_SQ_MID: r_prod <= r_prod + ({31'd0, w_mp, 1'b0} << 32);
                nmlet_pkg::ST_SQ_HI: begin
                    r_den <= 65'(r_prod >> FRACTION_BITS) + (65'd1 << FRACTION_BITS)
                        + (65'(w_mp) << (64 - FRACTION_BITS));
                end
                nmlet_pkg::ST_SUM: begin
                    if (w_s > 50'sd140737488355327) r_nx <= 48'sh7FFFFFFFFFFF;
                    else if (w_s < -50'sd140737488355328) r_nx <= 48'sh800000000000;
                    else r_nx <= w_s[47:0];
                    r_wasout <= 1'b0;
                end
                nmlet_pkg::ST_DIST: begin
                    r_end <= 1'b0;
                    // old value still in r_x, new one in r_nx
                    r_lensat <= w_ad > {2'b00, r_band};
                    r_wasout <= w_adp > {2'b00, r_band};
                end
                nmlet_pkg::ST_STAT: begin
                    r_x <= r_nx;
                    if (r_mode == nmlet_pkg::MODE_TRANS) begin
                        r_lam <= 1'b0; r_run <= '0;
                    end else if (!r_lam) begin
                        if (r_wasout && !r_lensat) begin r_lam <= 1'b1; r_run <= '0; end
                    end else if (r_lensat) begin
                        r_lam <= 1'b0; r_end <= 1'b1; r_run <= '0;
                        r_len <= 32'(w_run1);
                    end else begin
                        r_run <= w_run1;
                    end
                end
                nmlet_pkg::ST_SQR: r_prod <= {32'd0, w_mp};
                nmlet_pkg::ST_ACC: if (r_end) begin
                    if (r_tot != '1) r_tot <= r_tot + 1'b1;
                    r_sum <= w_sum[64] ? '1 : w_sum[63:0];
                    r_sq <= ((65'(r_sq) + 65'(r_prod[63:0])) >> 64) != 0 ? '1
                        : r_sq + r_prod[63:0];
                    if (r_len > r_peak) r_peak <= r_len;
                end
                default: ;
            endcase
        end
    end
    assign w_sum = 65'(r_sum) + 65'(r_len);
endmodule
`default_nettype wire

### dv/tb_neuron_map_laminar_episode_tracker.sv
`timescale 1ns / 1ps
module tb_neuron_map_laminar_episode_tracker;

    localparam int  FB        = 44;
    localparam int  LIMIT     = 2500000;
    localparam int  RAND_ITEMS = 1730;
    localparam logic signed [47:0] VMAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] VMIN = 48'sh8000_0000_0000;
    localparam logic [46:0] GMAX = 47'h7FFF_FFFF_FFFF;

    typedef struct {
        logic signed [47:0] value;
        logic               laminar;
        logic               ended;
        logic [31:0]        length;
        logic [31:0]        total;
        logic [63:0]        sum;
        logic [63:0]        sq_sum;
        logic [31:0]        peak;
    } t_beat;

    typedef struct {
        nmlet_pkg::t_mode   mode;
        logic signed [47:0] start;
        bit                 known;
        logic signed [47:0] value;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic pready;

    nmlet_in_if  in_ch();
    nmlet_out_if out_ch();

    neuron_map_laminar_episode_tracker uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .s_in(in_ch), .m_out(out_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #2 i_clk = ~i_clk;

    // predictor copy of the registers and state
    logic [46:0]        gain_q   = 47'd84442493013197;
    logic signed [47:0] offset_q = -48'sd51569539174795;
    logic signed [47:0] fixpt_q  = -48'sd31058273865894;
    logic [46:0]        band_q   = 47'd1759218604442;
    logic signed [47:0] x_q = '0;
    logic               lam_q = 1'b0;
    logic [31:0]        run_q = '0, eps_q = '0, peak_q = '0;
    logic [63:0]        s1_q = '0, s2_q = '0;

    t_beat expected_beats[$];
    logic signed [47:0] known_values[$];
    bit    known_flags[$];
    int    errors = 0;
    int    cycles = 0;
    bit    calm = 1'b0;
    bit    hold_req = 1'b0;
    bit    sender_done = 1'b0;

    function automatic logic signed [47:0] map_next(logic signed [47:0] x);
        logic [47:0]  mag;
        logic [127:0] sq, den, num, quo;
        logic signed [49:0] s;
        mag = x[47] ? (~x + 48'd1) : x;
        sq  = {80'b0, mag} * {80'b0, mag};
        den = (128'd1 << FB) + (sq >> FB);
        num = {81'b0, gain_q} << FB;
        quo = num / den;
        s = $signed({3'b000, quo[46:0]}) + $signed({{2{offset_q[47]}}, offset_q});
        if (s > $signed({{2{VMAX[47]}}, VMAX})) return VMAX;
        if (s < $signed({{2{VMIN[47]}}, VMIN})) return VMIN;
        return s[47:0];
    endfunction

    function automatic bit out_of_band(logic signed [47:0] v);
        logic signed [49:0] d;
        d = $signed({{2{v[47]}}, v}) - $signed({{2{fixpt_q[47]}}, fixpt_q});
        if (d < 0) d = -d;
        return d > $signed({3'b000, band_q});
    endfunction

    function automatic t_beat track_step(nmlet_pkg::t_mode m, logic signed [47:0] start);
        t_beat b;
        logic signed [47:0] nx;
        logic [64:0] acc;
        logic [63:0] sq;
        bit was_out, now_out;
        b.ended = 1'b0;
        b.length = '0;
        case (m)
            nmlet_pkg::MODE_LOAD: begin
                x_q = start; lam_q = 1'b0; run_q = '0;
            end
            nmlet_pkg::MODE_TRANS: begin
                x_q = map_next(x_q); lam_q = 1'b0; run_q = '0;
            end
            nmlet_pkg::MODE_MEAS: begin
                nx = map_next(x_q);
                was_out = out_of_band(x_q);
                now_out = out_of_band(nx);
                if (!lam_q) begin
                    if (was_out && !now_out) begin
                        lam_q = 1'b1; run_q = '0;
                    end
                end else begin
                    if (run_q != 32'hFFFF_FFFF) run_q++;
                    if (now_out) begin
                        lam_q = 1'b0;
                        b.ended = 1'b1;
                        b.length = run_q;
                        run_q = '0;
                        if (eps_q != 32'hFFFF_FFFF) eps_q++;
                        acc = {1'b0, s1_q} + {33'b0, b.length};
                        s1_q = acc[64] ? '1 : acc[63:0];
                        sq = {32'b0, b.length} * {32'b0, b.length};
                        acc = {1'b0, s2_q} + {1'b0, sq};
                        s2_q = acc[64] ? '1 : acc[63:0];
                        if (b.length > peak_q) peak_q = b.length;
                    end
                end
                x_q = nx;
            end
            default: begin
                eps_q = '0; s1_q = '0; s2_q = '0; peak_q = '0;
            end
        endcase
        b.value = x_q; b.laminar = lam_q; b.total = eps_q;
        b.sum = s1_q; b.sq_sum = s2_q; b.peak = peak_q;
        return b;
    endfunction

    task automatic report(string field, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h expected %h at cycle %0d", field, got, want, cycles);
        errors++;
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // accept monitor: predict on every input beat
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready)
            expected_beats.insert(expected_beats.size(),
                track_step(nmlet_pkg::t_mode'(in_ch.mode), in_ch.start_value));
    end

    // result checker
    always @(posedge i_clk) begin
        t_beat e;
        logic signed [47:0] kv;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_beats.size() == 0) begin
                report("unexpected beat", out_ch.next_value, '0);
            end else begin
                e = expected_beats.pop_front();
                if (known_flags.size() != 0) begin
                    kv = known_values.pop_front();
                    if (known_flags.pop_front() && out_ch.next_value !== kv)
                        report("typed next_value", out_ch.next_value, kv);
                end
                if (out_ch.next_value !== e.value)
                    report("next_value", out_ch.next_value, e.value);
                if (out_ch.laminar_now !== e.laminar)
                    report("laminar_now", out_ch.laminar_now, e.laminar);
                if (out_ch.episode_ended !== e.ended)
                    report("episode_ended", out_ch.episode_ended, e.ended);
                if (out_ch.episode_length !== e.length)
                    report("episode_length", out_ch.episode_length, e.length);
                if (out_ch.episode_total !== e.total)
                    report("episode_total", out_ch.episode_total, e.total);
                if (out_ch.length_sum !== e.sum)
                    report("length_sum", out_ch.length_sum, e.sum);
                if (out_ch.length_square_sum !== e.sq_sum)
                    report("length_square_sum", out_ch.length_square_sum, e.sq_sum);
                if (out_ch.length_peak !== e.peak)
                    report("length_peak", out_ch.length_peak, e.peak);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(30, 120);
    endfunction

    // result side: random stalls, one long hold on request
    initial begin
        int n;
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_req) begin
                @(negedge i_clk) out_ch.ready = 1'b0;
                n = 0;
                while (n < 800) begin
                    @(negedge i_clk);
                    n++;
                end
                hold_req = 1'b0;
            end
            n = pick_gap();
            if (n > 0) begin
                @(negedge i_clk) out_ch.ready = 1'b0;
                repeat (n - 1) @(negedge i_clk);
            end
            @(negedge i_clk) out_ch.ready = 1'b1;
            repeat ($urandom_range(0, 6)) @(negedge i_clk);
        end
    end

    task automatic send_item(nmlet_pkg::t_mode m, logic signed [47:0] start, bit known,
                             logic signed [47:0] kv);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk) in_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_ch.valid = 1'b1;
        in_ch.mode = m;
        in_ch.start_value = start;
        known_flags.insert(known_flags.size(), known);
        known_values.insert(known_values.size(), kv);
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic drain();
        @(negedge i_clk) in_ch.valid = 1'b0;
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(nmlet_pkg::t_reg idx, logic [63:0] data);
        @(negedge i_clk);
        psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
        paddr = 5'(8 * int'(idx)); pwdata = data;
        @(negedge i_clk) penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        case (idx)
            nmlet_pkg::REG_GAIN:   gain_q   = data[46:0];
            nmlet_pkg::REG_OFFSET: offset_q = data[47:0];
            nmlet_pkg::REG_FIXPT:  fixpt_q  = data[47:0];
            default:               band_q   = data[46:0];
        endcase
    endtask

    task automatic set_config(logic [46:0] g, logic signed [47:0] o,
                              logic signed [47:0] f, logic [46:0] w);
        write_reg(nmlet_pkg::REG_GAIN, {17'b0, g});
        write_reg(nmlet_pkg::REG_OFFSET, {{16{o[47]}}, o});
        write_reg(nmlet_pkg::REG_FIXPT, {{16{f[47]}}, f});
        write_reg(nmlet_pkg::REG_BAND, {17'b0, w});
    endtask

    function automatic logic signed [47:0] rand48();
        return {16'($urandom_range(0, 16'hFFFF)), $urandom()};
    endfunction

    t_row directed[] = '{
        '{nmlet_pkg::MODE_CLEAR, 48'sd0, 1'b1, 48'sd0},
        '{nmlet_pkg::MODE_LOAD, VMAX, 1'b1, VMAX},
        '{nmlet_pkg::MODE_MEAS, 48'sd0, 1'b0, 48'sd0},
        '{nmlet_pkg::MODE_LOAD, VMIN, 1'b1, VMIN},
        '{nmlet_pkg::MODE_MEAS, 48'sd0, 1'b0, 48'sd0},
        '{nmlet_pkg::MODE_LOAD, 48'sd0, 1'b1, 48'sd0},
        '{nmlet_pkg::MODE_TRANS, 48'sd0, 1'b1, 48'sd32872953838402},
        '{nmlet_pkg::MODE_LOAD, -48'sd31058273865894, 1'b1, -48'sd31058273865894},
        '{nmlet_pkg::MODE_MEAS, 48'sd0, 1'b0, 48'sd0},
        '{nmlet_pkg::MODE_LOAD, -48'sd1, 1'b1, -48'sd1},
        '{nmlet_pkg::MODE_LOAD, 48'sd1, 1'b1, 48'sd1},
        '{nmlet_pkg::MODE_LOAD, -48'sd28000000000000, 1'b1, -48'sd28000000000000},
        '{nmlet_pkg::MODE_MEAS, 48'sd0, 1'b0, 48'sd0},
        '{nmlet_pkg::MODE_MEAS, 48'sd0, 1'b0, 48'sd0},
        '{nmlet_pkg::MODE_MEAS, 48'sd0, 1'b0, 48'sd0},
        '{nmlet_pkg::MODE_CLEAR, 48'sd5, 1'b0, 48'sd0},
        '{nmlet_pkg::MODE_MEAS, 48'sd0, 1'b0, 48'sd0},
        '{nmlet_pkg::MODE_MEAS, 48'sd0, 1'b0, 48'sd0},
        '{nmlet_pkg::MODE_TRANS, 48'sd0, 1'b0, 48'sd0},
        '{nmlet_pkg::MODE_MEAS, 48'sd0, 1'b0, 48'sd0}
    };

    initial begin
        int sent;
        int steps;
        int p;
        logic signed [47:0] v;
        in_ch.valid = 1'b0;
        in_ch.mode = nmlet_pkg::MODE_LOAD;
        in_ch.start_value = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk) i_rst_n = 1'b1;

        foreach (directed[i])
            send_item(directed[i].mode, directed[i].start, directed[i].known,
                      directed[i].value);
        drain();

        sent = 0;
        p = 0;
        while (sent < RAND_ITEMS) begin
            case (p)
                0: set_config(GMAX, VMAX, VMAX, 47'd0);
                1: set_config(47'd0, VMIN, VMIN, GMAX);
                2: set_config(GMAX, VMIN, 48'sd0, 47'd1);
                3: set_config(47'd1, 48'sd0, 48'sd0, 47'd0);
                4: set_config(47'd84442493013197, -48'sd51569539174795,
                              -48'sd31058273865894, 47'd1759218604442);
                default: set_config(47'd84442493013197 + 47'($urandom_range(0, 1 << 30)),
                                    -48'sd51569539174795 + 48'($urandom_range(0, 1 << 28)),
                                    -48'sd31058273865894, 47'($urandom_range(1, 1 << 30))
                                    << $urandom_range(0, 14));
            endcase
            calm = (p == 5);
            if (p == 2) hold_req = 1'b1;
            repeat (10) begin
                if (sent < RAND_ITEMS) begin
                    if ($urandom_range(0, 99) < 85) begin
                        // well-formed: load near the band, settle, then measure
                        if ($urandom_range(0, 9) == 0) v = rand48();
                        else v = fixpt_q + 48'($signed({1'b0, band_q}) *
                                               ($urandom_range(0, 8) - 4)) +
                                 48'($signed(32'($urandom())));
                        send_item(nmlet_pkg::MODE_LOAD, v, 1'b0, '0);
                        sent++;
                        repeat ($urandom_range(0, 3)) begin
                            send_item(nmlet_pkg::MODE_TRANS, rand48(), 1'b0, '0);
                            sent++;
                        end
                        steps = $urandom_range(5, 40);
                        repeat (steps) begin
                            if ($urandom_range(0, 49) == 0) begin
                                send_item(nmlet_pkg::MODE_CLEAR, rand48(), 1'b0, '0);
                                sent++;
                            end
                            send_item(nmlet_pkg::MODE_MEAS, rand48(), 1'b0, '0);
                            sent++;
                        end
                    end else begin
                        send_item(nmlet_pkg::t_mode'($urandom_range(0, 3)), rand48(),
                                  1'b0, '0);
                        sent++;
                    end
                end
            end
            // pause the sender until every result is back
            drain();
            p++;
        end

        drain();
        repeat (150) @(posedge i_clk);
        if (errors == 0 && expected_beats.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
